@@ hw/rtl/phaw_pkg.sv @@
// ============================================================================
// phaw_pkg: shared types and constants
// Command codes, payload structs, queue entry and state encodings for the
// time-of-period histogram predictor.
// ============================================================================
package phaw_pkg;

    localparam int BINS       = 1440;
    localparam int BIN_W      = $clog2(BINS);
    localparam int ADDR_W     = BIN_W + 1;
    localparam int HALF_STEPS = BINS / 2;
    localparam int STEP_W     = $clog2(HALF_STEPS + 1);
    localparam int T_W        = 32;
    localparam int SCALED_W   = T_W + BIN_W;
    localparam int CNT_DIV_W  = $clog2(SCALED_W + 1);
    localparam int OBS_W      = 17;
    localparam int THR_W      = 24;
    localparam int VAL_W      = 48;
    localparam int CNT_W      = 24;
    localparam int HALF_VAL_W = VAL_W / 2;
    localparam int PROD_W     = HALF_VAL_W + CNT_W;
    localparam int SUM_W      = CNT_W + $clog2(BINS + 1);
    localparam int ACC_W      = VAL_W + SUM_W + 1;
    localparam int DCNT_W     = $clog2(ACC_W + 1);
    localparam int PROB_W     = 16;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [OBS_W-1:0]  Q_ONE     = OBS_W'(65536);
    localparam logic [PROB_W-1:0] Q_HALF    = PROB_W'(32768);
    localparam logic [PROB_W-1:0] P_LOW     = PROB_W'(66);
    localparam logic [PROB_W-1:0] P_HIGH    = PROB_W'(65470);
    localparam logic [T_W-1:0]    PERIOD_RST = T_W'(86400);
    localparam logic [THR_W-1:0]  THR_RST    = THR_W'(100);

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_PRED     = 2'd1,
        CMD_PRED_DEF = 2'd2,
        CMD_EST      = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        REG_PERIOD    = 1'b0,
        REG_THRESHOLD = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cmd              command;
        logic [T_W-1:0]    time_stamp;
        logic [OBS_W-1:0]  observation;
        logic [THR_W-1:0]  sample_threshold;
    } t_in;

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic              no_data;
    } t_out;

    typedef struct packed {
        t_cmd              cmd;
        logic [BIN_W-1:0]  bin;
        logic [OBS_W-1:0]  obs;
        logic [THR_W-1:0]  thr;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MOD,
        F_MUL,
        F_SCALE,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_RD,
        B_DATA,
        B_MHI,
        B_ACC,
        B_DIV,
        B_OUT
    } t_back_state;

endpackage

@@ hw/rtl/phaw_front.sv @@
// ============================================================================
// phaw_front: command intake and bin classification
// Holds the configuration registers, takes one command, resolves its
// threshold and finds its bin with a shared bit-serial divider.
// ============================================================================
module phaw_front import phaw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in              i_data,
    input  logic             i_hold,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [T_W-1:0]   i_cfg_data,
    output logic             o_push,
    output t_job             o_job,
    input  logic             i_full
);

    t_front_state r_state, n_state;
    logic [T_W-1:0]       r_period;
    logic [THR_W-1:0]     r_def_thr;
    logic [SCALED_W-1:0]  r_dvd;
    logic [T_W-1:0]       r_rem;
    logic [BIN_W-1:0]     r_quo;
    logic [CNT_DIV_W-1:0] r_cnt;
    t_job                 r_job;

    logic [T_W-1:0] period_eff;
    logic [T_W:0]   trial;
    logic           take;
    logic           accept;

    assign period_eff = (r_period == '0) ? T_W'(1) : r_period;
    assign trial      = {r_rem, r_dvd[SCALED_W-1]};
    assign take       = (trial >= {1'b0, period_eff});
    assign accept     = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (accept) n_state = F_MOD;
            F_MOD:   if (r_cnt == '0) n_state = F_MUL;
            F_MUL:   n_state = F_SCALE;
            F_SCALE: if (r_cnt == '0) n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == F_IDLE) && !i_hold;
        o_push  = (r_state == F_PUSH) && !i_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_period  <= PERIOD_RST;
            r_def_thr <= THR_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_PERIOD:    r_period  <= i_cfg_data;
                    REG_THRESHOLD: r_def_thr <= i_cfg_data[THR_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_job.cmd <= i_data.command;
                r_job.obs <= (i_data.observation > Q_ONE) ? Q_ONE : i_data.observation;
                r_job.thr <= (i_data.command == CMD_PRED) ? i_data.sample_threshold
                                                          : r_def_thr;
                r_dvd     <= {i_data.time_stamp, BIN_W'(0)};
                r_rem     <= '0;
                r_cnt     <= CNT_DIV_W'(T_W - 1);
            end
            F_MOD, F_SCALE: begin
                r_rem <= take ? T_W'(trial - {1'b0, period_eff}) : trial[T_W-1:0];
                r_dvd <= {r_dvd[SCALED_W-2:0], 1'b0};
                r_quo <= {r_quo[BIN_W-2:0], take};
                r_cnt <= r_cnt - 1'b1;
            end
            F_MUL: begin
                r_dvd <= SCALED_W'(r_rem * SCALED_W'(BINS));
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CNT_DIV_W'(SCALED_W - 1);
            end
            F_PUSH: r_job.bin <= r_quo;
            default: ;
        endcase
    end

    always_comb begin
        o_job     = r_job;
        o_job.bin = r_quo;
    end

endmodule

@@ hw/rtl/phaw_queue.sv @@
// ============================================================================
// phaw_queue: job queue
// Small FIFO between the classifier and the histogram engine.
// ============================================================================
module phaw_queue import phaw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

@@ hw/rtl/phaw_back.sv @@
// ============================================================================
// phaw_back: histogram engine
// Owns the bin memories, applies adds, walks the ring for predictions,
// divides the weighted sum and holds the result register.
// ============================================================================
module phaw_back import phaw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_job i_job,
    output logic o_pop,
    output logic o_busy,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic [VAL_W-1:0] r_val_mem [BINS];
    logic [CNT_W-1:0] r_cnt_mem [BINS];

    t_back_state r_state, n_state;
    logic [BIN_W-1:0]  r_clr;
    logic [BIN_W-1:0]  r_addr;
    logic [BIN_W-1:0]  r_center;
    t_cmd              r_cmd;
    logic [OBS_W-1:0]  r_obs;
    logic [THR_W-1:0]  r_thr;
    logic [VAL_W-1:0]  r_rd_val;
    logic [CNT_W-1:0]  r_rd_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic [ACC_W-1:0]  r_acc;
    logic [PROD_W-1:0] r_prod;
    logic [STEP_W-1:0] r_i;
    logic              r_minus;
    logic [SUM_W:0]    r_rem;
    logic [PROB_W-1:0] r_q;
    logic              r_ovf;
    logic [DCNT_W-1:0] r_dcnt;
    logic [PROB_W-1:0] r_prob;
    logic              r_nodata;
    logic              r_out_valid;
    t_out              r_out;

    logic              we;
    logic [BIN_W-1:0]  wa;
    logic [VAL_W-1:0]  wv;
    logic [CNT_W-1:0]  wc;
    logic              rd_en;
    logic [VAL_W:0]    val_sum;
    logic              walk_more;
    logic [ADDR_W-1:0] plus_addr, minus_addr;
    logic [SUM_W+1:0]  trial;
    logic              take;
    logic              out_free;
    logic [PROB_W-1:0] est_prob, div_prob;

    assign val_sum    = {1'b0, r_rd_val} + (VAL_W+1)'(r_obs);
    assign walk_more  = (r_sum < SUM_W'(r_thr)) && (r_i < STEP_W'(HALF_STEPS));
    assign plus_addr  = ADDR_W'(r_center) + ADDR_W'(r_i) + ADDR_W'(1);
    assign minus_addr = ADDR_W'(r_center) + ADDR_W'(BINS) - ADDR_W'(r_i);
    assign trial      = {r_rem, r_acc[ACC_W-1]};
    assign take       = (trial >= (SUM_W+2)'(r_sum));
    assign out_free   = !r_out_valid || i_ready;

    assign est_prob = (r_rd_val > VAL_W'(P_HIGH)) ? P_HIGH :
                      (r_rd_val < VAL_W'(P_LOW))  ? P_LOW  : r_rd_val[PROB_W-1:0];
    assign div_prob = (r_ovf || r_q > P_HIGH) ? P_HIGH :
                      (r_q < P_LOW) ? P_LOW : r_q;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: if (r_clr == BIN_W'(BINS - 1)) n_state = B_IDLE;
            B_IDLE:  if (!i_empty) n_state = B_RD;
            B_RD:    n_state = B_DATA;
            B_DATA: begin
                case (r_cmd)
                    CMD_ADD: n_state = B_IDLE;
                    CMD_EST: n_state = B_OUT;
                    default: n_state = B_MHI;
                endcase
            end
            B_MHI:   n_state = B_ACC;
            B_ACC: begin
                if (!r_minus || walk_more) n_state = B_RD;
                else if (r_sum == '0)      n_state = B_OUT;
                else                       n_state = B_DIV;
            end
            B_DIV:   if (r_dcnt == '0) n_state = B_OUT;
            B_OUT:   if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == B_IDLE) && !i_empty;
        o_busy = (r_state == B_CLEAR);
        rd_en  = (r_state == B_RD);
        we     = (r_state == B_CLEAR) || ((r_state == B_DATA) && (r_cmd == CMD_ADD));
        wa     = (r_state == B_CLEAR) ? r_clr : r_addr;
        if (r_state == B_CLEAR) begin
            wv = VAL_W'(Q_HALF);
            wc = '0;
        end else begin
            wv = val_sum[VAL_W] ? {VAL_W{1'b1}} : val_sum[VAL_W-1:0];
            wc = (r_rd_cnt == {CNT_W{1'b1}}) ? r_rd_cnt : r_rd_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_val_mem[wa] <= wv;
            r_cnt_mem[wa] <= wc;
        end
        if (rd_en) begin
            r_rd_val <= r_val_mem[r_addr];
            r_rd_cnt <= r_cnt_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) r_clr <= r_clr + 1'b1;
            if ((r_state == B_OUT) && out_free) r_out_valid <= 1'b1;
            else if (i_ready)                   r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_cmd    <= i_job.cmd;
                r_obs    <= i_job.obs;
                r_thr    <= i_job.thr;
                r_center <= i_job.bin;
                r_addr   <= i_job.bin;
                r_sum    <= '0;
                r_acc    <= '0;
                r_i      <= '0;
                r_minus  <= 1'b1;
                r_nodata <= 1'b0;
            end
            B_DATA: begin
                r_prob <= est_prob;
                r_sum  <= r_sum + SUM_W'(r_rd_cnt);
                r_prod <= r_rd_val[HALF_VAL_W-1:0] * r_rd_cnt;
            end
            B_MHI: begin
                r_acc  <= r_acc + ACC_W'(r_prod);
                r_prod <= r_rd_val[VAL_W-1:HALF_VAL_W] * r_rd_cnt;
            end
            B_ACC: begin
                r_acc <= r_acc + (ACC_W'(r_prod) << HALF_VAL_W);
                if (!r_minus) begin
                    r_minus <= 1'b1;
                    r_addr  <= (minus_addr >= ADDR_W'(BINS)) ?
                               BIN_W'(minus_addr - ADDR_W'(BINS)) : BIN_W'(minus_addr);
                end else if (walk_more) begin
                    r_minus <= 1'b0;
                    r_i     <= r_i + 1'b1;
                    r_addr  <= (plus_addr >= ADDR_W'(BINS)) ?
                               BIN_W'(plus_addr - ADDR_W'(BINS)) : BIN_W'(plus_addr);
                end else begin
                    r_nodata <= (r_sum < SUM_W'(r_thr));
                    r_prob   <= Q_HALF;
                    r_rem    <= '0;
                    r_q      <= '0;
                    r_ovf    <= 1'b0;
                    r_dcnt   <= DCNT_W'(ACC_W - 1);
                end
            end
            B_DIV: begin
                r_rem  <= take ? (SUM_W+1)'(trial - (SUM_W+2)'(r_sum)) : trial[SUM_W:0];
                r_acc  <= {r_acc[ACC_W-2:0], 1'b0};
                r_q    <= {r_q[PROB_W-2:0], take};
                r_ovf  <= r_ovf | r_q[PROB_W-1];
                r_dcnt <= r_dcnt - 1'b1;
            end
            B_OUT: begin
                if (out_free) begin
                    r_out.probability <= (r_cmd == CMD_EST || r_sum == '0) ? r_prob
                                                                          : div_prob;
                    r_out.no_data     <= r_nodata;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_sum != '0))
        else $error("division entered with zero count sum");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_CLEAR && r_state != B_IDLE) |-> (r_i <= STEP_W'(HALF_STEPS)))
        else $error("ring walk exceeded half the ring");
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we || rd_en) |-> ((we ? wa : r_addr) < BIN_W'(BINS)))
        else $error("bin address out of range");
`endif

endmodule

@@ hw/rtl/periodic_histogram_adaptive_window_top.sv @@
// ============================================================================
// periodic_histogram_adaptive_window_top: time-of-period histogram predictor
// Adds observations into period bins and answers windowed predictions.
// ============================================================================
// After reset the bin memories are cleared; no transfer is taken meanwhile.
// Bin lookup uses a one-bit-per-cycle divider. In the engine an add passes
// the read and data states, an estimate read, data and output. A prediction
// reads 1 + 2*w bins, w being the widening needed, each through read, data,
// high-multiply and accumulate (one memory port, split multiply), then
// divides. A four-entry queue lets classification overlap execution.
module periodic_histogram_adaptive_window_top import phaw_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  t_in            i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output t_out           o_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [T_W-1:0] i_cfg_data
);

    logic push, full, pop, empty, busy;
    t_job job_in, job_out;

    phaw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_hold     (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_job      (job_in),
        .i_full     (full)
    );

    phaw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    phaw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_busy  (busy),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
